>>> rtl/i2crm_pkg.sv
// package for the i2c register master: field widths, codes, item types
// no dependencies
`default_nettype none
package i2crm_pkg;
   localparam int TickBitsDefault = 16;
   localparam logic [11:0] QuarterReset = 12'd400;
   localparam logic [11:0] AckLimitReset = 12'd400;
   localparam logic [15:0] BusFreeReset = 16'd2000;
   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits = 16;
   localparam logic [1:0] CSR_QUARTER = 2'd0;
   localparam logic [1:0] CSR_ACK_LIMIT = 2'd1;
   localparam logic [1:0] CSR_BUS_FREE = 2'd2;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_WR_ADDR_NACK = 2'd1;
   localparam logic [1:0] ST_WR_DATA_NACK = 2'd2;
   localparam logic [1:0] ST_RD_ADDR_NACK = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic       is_tick;
      logic       is_cmd;
      logic       is_read;
      logic [6:0] device;
      logic [7:0] register;
      logic [7:0] data;
      logic       sda;
   } cmd_type;
endpackage
`default_nettype wire

>>> rtl/i2crm_if.sv
// valid/ready channel interface carrying one item
// depends on nothing but its type parameter
`default_nettype none
interface i2crm_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/i2crm_front.sv
// front: accepts request items, classifies them, two-entry queue to the back
// depends on i2crm_pkg
`default_nettype none
module i2crm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire i2crm_pkg::req_type in_item,
   output logic                    q_valid,
   input  wire logic               q_pop,
   output i2crm_pkg::cmd_type      q_item
);
   import i2crm_pkg::*;
   cmd_type   mem_ff [2];
   logic      wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   cmd_type   cls;
   logic      push;

   always_comb begin
      cls.is_tick = (in_item.func == FUNC_TICK);
      cls.is_cmd = (in_item.func == FUNC_WRITE) || (in_item.func == FUNC_READ);
      cls.is_read = (in_item.func == FUNC_READ);
      cls.device = in_item.device_address;
      cls.register = in_item.register_address;
      cls.data = in_item.write_data;
      cls.sda = in_item.sda_in;
   end

   assign in_ready = (count_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = mem_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> count_ff == $past(count_ff) + 2'd1) else $error("count");
`endif
endmodule
`default_nettype wire

>>> rtl/i2crm_back.sv
// back: bit-level i2c sequencer, one queued item per cycle while the output is not stalled, registered result
// depends on i2crm_pkg
`default_nettype none
module i2crm_back #(
   parameter int TICK_COUNTER_BITS = i2crm_pkg::TickBitsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [11:0]        quarter,
   input  wire logic [11:0]        ack_limit,
   input  wire logic [15:0]        bus_free,
   input  wire logic               q_valid,
   output logic                    q_pop,
   input  wire i2crm_pkg::cmd_type q_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output i2crm_pkg::rsp_type      out_item
);
   import i2crm_pkg::*;
   localparam logic [2:0] PH_IDLE = 3'd0, PH_START = 3'd1, PH_TX = 3'd2,
      PH_ACK = 3'd3, PH_RX = 3'd4, PH_STOP = 3'd5, PH_GAP = 3'd6;
   localparam int TB = TICK_COUNTER_BITS;
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};

   logic [2:0] phase_ff, phase_in;
   logic [1:0] edge_ff, edge_in;
   logic [TB-1:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   logic [1:0] step_ff, step_in;
   logic read_ff, read_in;
   logic [6:0] dev_ff, dev_in;
   logic [7:0] reg_ff, reg_in, dat_ff, dat_in, shift_ff, shift_in;
   logic [11:0] polls_ff, polls_in;
   logic [1:0] stat_ff, stat_in;
   logic scl_ff, scl_in, sda_ff, sda_in_r;
   logic done;
   logic [TB-1:0] reload, gap_load;
   logic [11:0] qv, limit, polls_inc;
   logic out_valid_ff;
   rsp_type out_ff, res;

   assign q_pop = q_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_item = out_ff;

   always_comb begin
      qv = (quarter == 12'd0) ? 12'd1 : quarter;
      limit = (ack_limit == 12'd0) ? 12'd1 : ack_limit;
      polls_inc = polls_ff + 12'd1;
      // reload wraps at the counter width
      reload = TB'(qv - 12'd1);
      if (TB >= 16) gap_load = TB'(bus_free);
      else gap_load = (bus_free > 16'(TMAX)) ? TMAX : TB'(bus_free);
   end

   always_comb begin
      phase_in = phase_ff; edge_in = edge_ff; tick_in = tick_ff; bit_in = bit_ff;
      step_in = step_ff; read_in = read_ff; dev_in = dev_ff; reg_in = reg_ff;
      dat_in = dat_ff; shift_in = shift_ff; polls_in = polls_ff; stat_in = stat_ff;
      scl_in = scl_ff; sda_in_r = sda_ff; done = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (q_item.is_cmd) begin
            dev_in = q_item.device; reg_in = q_item.register; dat_in = q_item.data;
            read_in = q_item.is_read; step_in = 2'd0; stat_in = ST_OK;
            polls_in = 12'd0; shift_in = 8'd0; phase_in = PH_START;
            edge_in = 2'd0; bit_in = 4'd0; tick_in = '0;
         end
      end else if (q_item.is_tick) begin
         if (phase_ff == PH_GAP) begin
            if (tick_ff == '0) begin
               phase_in = PH_IDLE; edge_in = 2'd0; bit_in = 4'd0;
            end else tick_in = tick_ff - 1'b1;
         end else if (phase_ff == PH_ACK && edge_ff == 2'd2) begin
            if (!q_item.sda) begin
               edge_in = 2'd3; tick_in = reload;
            end else begin
               polls_in = polls_inc;
               if (polls_inc >= limit) begin
                  stat_in = read_ff ? ST_RD_ADDR_NACK :
                     (step_ff == 2'd2 ? ST_WR_DATA_NACK : ST_WR_ADDR_NACK);
                  phase_in = PH_STOP; edge_in = 2'd0; bit_in = 4'd0; tick_in = reload;
               end
            end
         end else if (tick_ff != '0) begin
            tick_in = tick_ff - 1'b1;
         end else begin
            tick_in = reload;
            case (phase_ff)
               PH_START: begin
                  case (edge_ff)
                     2'd0: sda_in_r = 1'b1;
                     2'd1: scl_in = 1'b1;
                     2'd2: sda_in_r = 1'b0;
                     default: scl_in = 1'b0;
                  endcase
               end
               default: ;
            endcase
            // (full edge handling below; start case above covers its pin effects)
            case (phase_ff)
               PH_START: begin
                  if (edge_ff == 2'd3) begin
                     // start byte with current step, first bit edge follows at once
                     phase_in = PH_TX; edge_in = 2'd0; bit_in = 4'd0; tick_in = '0;
                     shift_in = (step_ff == 2'd0) ? {dev_ff, 1'b0} :
                        (step_ff == 2'd1) ? reg_ff :
                        (read_ff ? {dev_ff, 1'b1} : dat_ff);
                  end else edge_in = edge_ff + 2'd1;
               end
               PH_TX: begin
                  if (edge_ff == 2'd0) begin
                     sda_in_r = shift_ff[3'd7 - bit_ff[2:0]]; edge_in = 2'd1;
                  end else if (edge_ff == 2'd1) begin
                     scl_in = 1'b1; edge_in = 2'd2;
                  end else begin
                     scl_in = 1'b0; edge_in = 2'd0; bit_in = bit_ff + 4'd1;
                     if (bit_ff + 4'd1 >= 4'd8) begin
                        phase_in = PH_ACK; bit_in = 4'd0; polls_in = 12'd0;
                     end
                  end
               end
               PH_ACK: begin
                  if (edge_ff == 2'd0) begin
                     sda_in_r = 1'b1; edge_in = 2'd1;
                  end else if (edge_ff == 2'd1) begin
                     scl_in = 1'b1; edge_in = 2'd2;
                  end else begin
                     scl_in = 1'b0; edge_in = 2'd0; bit_in = 4'd0;
                     if (step_ff == 2'd0) begin
                        step_in = 2'd1; phase_in = PH_TX; shift_in = reg_ff;
                     end else if (step_ff == 2'd1) begin
                        step_in = 2'd2;
                        if (read_ff) phase_in = PH_START;
                        else begin
                           phase_in = PH_TX; shift_in = dat_ff;
                        end
                     end else if (read_ff) begin
                        shift_in = 8'd0; phase_in = PH_RX;
                     end else phase_in = PH_STOP;
                  end
               end
               PH_RX: begin
                  if (edge_ff == 2'd0) begin
                     sda_in_r = 1'b1; edge_in = 2'd1;
                  end else if (edge_ff == 2'd1) begin
                     scl_in = 1'b1; edge_in = 2'd2;
                  end else begin
                     if (bit_ff < 4'd8) shift_in = {shift_ff[6:0], q_item.sda};
                     scl_in = 1'b0; edge_in = 2'd0; bit_in = bit_ff + 4'd1;
                     if (bit_ff + 4'd1 > 4'd8) begin
                        phase_in = PH_STOP; bit_in = 4'd0;
                     end
                  end
               end
               PH_STOP: begin
                  case (edge_ff)
                     2'd0: scl_in = 1'b0;
                     2'd1: sda_in_r = 1'b0;
                     2'd2: scl_in = 1'b1;
                     default: begin
                        sda_in_r = 1'b1; done = 1'b1; phase_in = PH_GAP;
                        bit_in = 4'd0; tick_in = gap_load;
                     end
                  endcase
                  edge_in = edge_ff + 2'd1;
               end
               default: begin
                  phase_in = PH_IDLE; edge_in = 2'd0; bit_in = 4'd0;
               end
            endcase
         end
      end
   end

   always_comb begin
      res.scl_level = scl_in;
      res.sda_release = sda_in_r;
      res.busy_res = (phase_in != PH_IDLE);
      res.done_res = done;
      res.status = stat_in;
      res.read_data = (done && read_ff && stat_in == ST_OK) ? shift_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) out_ff <= res;
      if (reset) begin
         phase_ff <= PH_IDLE; edge_ff <= 2'd0; tick_ff <= '0; bit_ff <= 4'd0;
         step_ff <= 2'd0; read_ff <= 1'b0; shift_ff <= 8'd0; polls_ff <= 12'd0;
         stat_ff <= ST_OK; scl_ff <= 1'b1; sda_ff <= 1'b1; out_valid_ff <= 1'b0;
         dev_ff <= 7'd0; reg_ff <= 8'd0; dat_ff <= 8'd0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in; edge_ff <= edge_in; tick_ff <= tick_in;
            bit_ff <= bit_in; step_ff <= step_in; read_ff <= read_in;
            shift_ff <= shift_in; polls_ff <= polls_in; stat_ff <= stat_in;
            scl_ff <= scl_in; sda_ff <= sda_in_r;
            dev_ff <= dev_in; reg_ff <= reg_in; dat_ff <= dat_in;
         end
         if (q_pop) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_idle_gap: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.done_res |-> phase_ff == PH_GAP) else $error("done");
   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.done_res |-> out_ff.read_data == 8'd0) else $error("rd");
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'd8) else $error("bit index");
`endif
endmodule
`default_nettype wire

>>> rtl/i2c_register_master_top.sv
// top level of the pin-level i2c register master
// depends on i2crm_pkg, i2crm_if, i2crm_front, i2crm_back
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, device_address, register_address, write_data, sda_in
//   rsp      out  valid/ready    scl_level, sda_release, busy_res, done_res, status, read_data
//   csr      in   write enable   quarter period, ack wait limit, bus free gap
//
// one item per clock while rsp is not stalled: each item advances the sequencer once in the back
// a two-entry queue separates the request side from the sequencer and output register
// a stalled rsp side holds the sequencer; req keeps taking items until the queue fills
// synchronous reset returns to idle with scl high, sda released and reset registers
`default_nettype none
module i2c_register_master_top #(
   parameter int TICK_COUNTER_BITS = i2crm_pkg::TickBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   i2crm_if.sink    req,
   i2crm_if.source  rsp,
   input wire logic                              csr_write_enable,
   input wire logic [i2crm_pkg::CsrIndexBits-1:0] csr_index,
   input wire logic [i2crm_pkg::CsrDataBits-1:0]  csr_write_data
);
   import i2crm_pkg::*;
   // configuration registers
   logic [11:0] quarter_ff, ack_limit_ff;
   logic [15:0] bus_free_ff;
   // queue between front and back
   logic q_valid, q_pop;
   cmd_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= QuarterReset;
         ack_limit_ff <= AckLimitReset;
         bus_free_ff <= BusFreeReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_QUARTER: quarter_ff <= csr_write_data[11:0];
            CSR_ACK_LIMIT: ack_limit_ff <= csr_write_data[11:0];
            CSR_BUS_FREE: bus_free_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   i2crm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_item(req.payload),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   i2crm_back #(.TICK_COUNTER_BITS(TICK_COUNTER_BITS)) u_back (
      .clock(clock), .reset(reset),
      .quarter(quarter_ff), .ack_limit(ack_limit_ff), .bus_free(bus_free_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_item(rsp.payload)
   );
endmodule
`default_nettype wire
